>>> rtl/c39_pkg.sv
`default_nettype none
package c39_pkg;

  localparam int unsigned PosW  = 24;
  localparam int unsigned OffW  = 12;
  localparam int unsigned NBars = 5;
  localparam int unsigned NElem = 9;

  localparam logic [1:0] REQ_BEGIN  = 2'd0;
  localparam logic [1:0] REQ_DATA   = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [2:0] CFG_NARROW_WIDTH = 3'd0;
  localparam logic [2:0] CFG_WIDE_WIDTH   = 3'd1;
  localparam logic [2:0] CFG_BAR_HEIGHT   = 3'd2;
  localparam logic [2:0] CFG_START_X      = 3'd3;
  localparam logic [2:0] CFG_START_Y      = 3'd4;

  localparam logic [7:0]  RST_NARROW_WIDTH = 8'd8;
  localparam logic [7:0]  RST_WIDE_WIDTH   = 8'd20;
  localparam logic [15:0] RST_BAR_HEIGHT   = 16'd75;
  localparam logic [15:0] RST_START_X      = 16'd0;
  localparam logic [15:0] RST_START_Y      = 16'd0;

  // element 0 of a character sits in the msb
  localparam logic [NElem-1:0] PAT_DELIM = 9'b010010100;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] ch;
  } in_t;

  typedef struct packed {
    logic [23:0] bar_x;
    logic [15:0] bar_y;
    logic [7:0]  bar_width;
    logic [15:0] bar_height_res;
    logic        last_bar;
  } out_t;

  typedef struct packed {
    logic [NBars-1:0][PosW-1:0] x;
    logic [NBars-1:0]           wide;
  } bar_set_t;

  function automatic logic [NElem-1:0] pattern_for(input logic [7:0] ch);
    logic [7:0]       c;
    logic [NElem-1:0] p;
    c = ch;
    if (ch inside {[8'h61:8'h7A]}) begin
      c = ch - 8'd32;
    end
    case (c)
      8'h30: p = 9'b000110100;
      8'h31: p = 9'b100100001;
      8'h32: p = 9'b001100001;
      8'h33: p = 9'b101100000;
      8'h34: p = 9'b000110001;
      8'h35: p = 9'b100110000;
      8'h36: p = 9'b001110000;
      8'h37: p = 9'b000100101;
      8'h38: p = 9'b100100100;
      8'h39: p = 9'b001100100;
      8'h41: p = 9'b100001001;
      8'h42: p = 9'b001001001;
      8'h43: p = 9'b101001000;
      8'h44: p = 9'b000011001;
      8'h45: p = 9'b100011000;
      8'h46: p = 9'b001011000;
      8'h47: p = 9'b000001101;
      8'h48: p = 9'b100001100;
      8'h49: p = 9'b001001100;
      8'h4A: p = 9'b000011100;
      8'h4B: p = 9'b100000011;
      8'h4C: p = 9'b001000011;
      8'h4D: p = 9'b101000010;
      8'h4E: p = 9'b000010011;
      8'h4F: p = 9'b100010010;
      8'h50: p = 9'b001010010;
      8'h51: p = 9'b000000111;
      8'h52: p = 9'b100000110;
      8'h53: p = 9'b001000110;
      8'h54: p = 9'b000010110;
      8'h55: p = 9'b110000001;
      8'h56: p = 9'b011000001;
      8'h57: p = 9'b111000000;
      8'h58: p = 9'b010010001;
      8'h59: p = 9'b110010000;
      8'h5A: p = 9'b011010000;
      8'h2D: p = 9'b010000101;
      8'h2E: p = 9'b110000100;
      8'h20: p = 9'b011000100;
      8'h2B: p = 9'b010001010;
      8'h25: p = 9'b000101010;
      8'h24: p = 9'b010101000;
      8'h2F: p = 9'b010100010;
      default: p = PAT_DELIM;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

>>> rtl/c39_in_reg.sv
`default_nettype none
module c39_in_reg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire c39_pkg::in_t in_data,
  input  wire logic         ser_free,
  output c39_pkg::in_t      item,
  output logic              fire,
  output logic              busy
);

  logic         valid_r;
  logic         valid_nxt;
  c39_pkg::in_t item_r;
  logic         drop;
  logic         move;

  // unused request type leaves without producing bars
  assign drop     = (item_r.req_type == c39_pkg::REQ_UNUSED);
  assign move     = valid_r && (ser_free || drop);
  assign fire     = valid_r && ser_free && !drop;
  assign in_ready = !valid_r || move;
  assign item     = item_r;
  assign busy     = valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (move) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/c39_bar_calc.sv
`default_nettype none
module c39_bar_calc (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire c39_pkg::in_t item,
  input  wire logic         fire,
  input  wire logic [7:0]   narrow_width,
  input  wire logic [7:0]   wide_width,
  input  wire logic [15:0]  start_x,
  output c39_pkg::bar_set_t bars
);

  logic [c39_pkg::PosW-1:0]  x_position_r;
  logic [c39_pkg::PosW-1:0]  x_position_nxt;
  logic [c39_pkg::PosW-1:0]  base;
  logic [c39_pkg::NElem-1:0] pat;
  logic [c39_pkg::NElem-1:0] wide_el;
  logic [7:0]                w [c39_pkg::NElem];
  logic [8:0]                pair [4];
  logic [c39_pkg::OffW-1:0]  off [c39_pkg::NBars];
  logic [c39_pkg::OffW-1:0]  total;

  function automatic logic [c39_pkg::PosW-1:0] sat_add(
    input logic [c39_pkg::PosW-1:0] a,
    input logic [c39_pkg::OffW-1:0] b
  );
    logic [c39_pkg::PosW:0] s;
    s = {1'b0, a} + (c39_pkg::PosW+1)'(b);
    return s[c39_pkg::PosW] ? {c39_pkg::PosW{1'b1}} : s[c39_pkg::PosW-1:0];
  endfunction

  assign pat  = (item.req_type == c39_pkg::REQ_DATA) ? c39_pkg::pattern_for(item.ch)
                                                     : c39_pkg::PAT_DELIM;
  assign base = (item.req_type == c39_pkg::REQ_BEGIN) ? {8'd0, start_x} : x_position_r;

  always_comb begin
    for (int e = 0; e < c39_pkg::NElem; e++) begin
      wide_el[e] = pat[c39_pkg::NElem-1-e];
      w[e]       = wide_el[e] ? wide_width : narrow_width;
    end
    for (int j = 0; j < 4; j++) begin
      pair[j] = {1'b0, w[2*j]} + {1'b0, w[2*j+1]};
    end
    // offset of each bar from the character start
    off[0] = '0;
    off[1] = c39_pkg::OffW'(pair[0]);
    off[2] = off[1] + c39_pkg::OffW'(pair[1]);
    off[3] = off[2] + c39_pkg::OffW'(pair[2]);
    off[4] = off[3] + c39_pkg::OffW'(pair[3]);
    total  = off[4] + c39_pkg::OffW'(w[8]) + c39_pkg::OffW'(narrow_width);
    for (int k = 0; k < c39_pkg::NBars; k++) begin
      bars.x[k]    = sat_add(base, off[k]);
      bars.wide[k] = wide_el[2*k];
    end
    x_position_nxt = fire ? sat_add(base, total) : x_position_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_position_r <= '0;
    end else begin
      x_position_r <= x_position_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/c39_bar_ser.sv
`default_nettype none
module c39_bar_ser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire c39_pkg::bar_set_t bars,
  output logic                   free,
  input  wire logic [7:0]        narrow_width,
  input  wire logic [7:0]        wide_width,
  input  wire logic [15:0]       bar_height,
  input  wire logic [15:0]       start_y,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output c39_pkg::out_t          out_data
);

  logic                               valid_r;
  logic                               valid_nxt;
  logic [2:0]                         cnt_r;
  logic [2:0]                         cnt_nxt;
  logic [c39_pkg::NBars-1:0][23:0]    x_r;
  logic [c39_pkg::NBars-1:0]          wide_r;
  logic                               take;
  logic                               last;

  assign last      = (cnt_r == 3'(c39_pkg::NBars - 1));
  assign take      = valid_r && out_ready;
  assign free      = !valid_r || (out_ready && last);
  assign out_valid = valid_r;

  assign out_data.bar_x          = x_r[0];
  assign out_data.bar_y          = start_y;
  assign out_data.bar_width      = wide_r[0] ? wide_width : narrow_width;
  assign out_data.bar_height_res = bar_height;
  assign out_data.last_bar       = last;

  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      valid_nxt = 1'b1;
      cnt_nxt   = '0;
    end else if (take) begin
      if (last) begin
        valid_nxt = 1'b0;
      end
      cnt_nxt = cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // bars leave from slot 0, the rest shift down
  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= bars.x;
      wide_r <= bars.wide;
    end else if (take) begin
      for (int k = 0; k < c39_pkg::NBars - 1; k++) begin
        x_r[k]    <= x_r[k+1];
        wide_r[k] <= wide_r[k+1];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/code39_bar_generator_core.sv
`default_nettype none
// Code 39 bar generator. Each request (begin, data character, finish) yields five
// bar rectangles on the result channel, one per cycle while out_ready is high, the
// fifth marked last_bar; a request with req_type 3 yields nothing. A request waits
// in the input register, where the position logic works on it combinationally, then
// moves into the output shifter, which delivers a single result per cycle while
// out_ready is high. The next request
// is taken while the current bars are still leaving. Begin reloads the x position
// from start_x; x saturates at its 24-bit maximum. Configuration writes are taken at
// any time with cfg_ready held high, but should only be made while no request is in
// flight.
module code39_bar_generator_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire c39_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output c39_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_wdata
);

  logic [7:0]        narrow_width_r;
  logic [7:0]        wide_width_r;
  logic [15:0]       bar_height_r;
  logic [15:0]       start_x_r;
  logic [15:0]       start_y_r;
  c39_pkg::in_t      item;
  logic              fire;
  logic              busy;
  logic              ser_free;
  c39_pkg::bar_set_t bars;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      narrow_width_r <= c39_pkg::RST_NARROW_WIDTH;
      wide_width_r   <= c39_pkg::RST_WIDE_WIDTH;
      bar_height_r   <= c39_pkg::RST_BAR_HEIGHT;
      start_x_r      <= c39_pkg::RST_START_X;
      start_y_r      <= c39_pkg::RST_START_Y;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        c39_pkg::CFG_NARROW_WIDTH: narrow_width_r <= cfg_wdata[7:0];
        c39_pkg::CFG_WIDE_WIDTH:   wide_width_r   <= cfg_wdata[7:0];
        c39_pkg::CFG_BAR_HEIGHT:   bar_height_r   <= cfg_wdata;
        c39_pkg::CFG_START_X:      start_x_r      <= cfg_wdata;
        c39_pkg::CFG_START_Y:      start_y_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  c39_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .ser_free (ser_free),
    .item     (item),
    .fire     (fire),
    .busy     (busy)
  );

  c39_bar_calc u_bar_calc (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (item),
    .fire         (fire),
    .narrow_width (narrow_width_r),
    .wide_width   (wide_width_r),
    .start_x      (start_x_r),
    .bars         (bars)
  );

  c39_bar_ser u_bar_ser (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (fire),
    .bars         (bars),
    .free         (ser_free),
    .narrow_width (narrow_width_r),
    .wide_width   (wide_width_r),
    .bar_height   (bar_height_r),
    .start_y      (start_y_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  // the bars of one character keep coming until the last one
  a_char_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_bar |=> out_valid)
    else $error("bar sequence broken before last bar");

  // x never moves left within a character
  a_x_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_bar |=>
      out_data.bar_x >= $past(out_data.bar_x))
    else $error("bar x decreased within a character");

  // an empty input register always takes a request
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> in_ready)
    else $error("input stalled while empty");

  // a new character only enters the shifter when the old one has left
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fire && out_valid |-> out_ready && out_data.last_bar)
    else $error("shifter loaded while bars pending");

endmodule
`default_nettype wire
